/* rtl/core/z80alu_pkg.sv */
// ----------------------------------------------------------------------------
// Z80 8-bit ALU package
// Beat types, operation codes and flag bit positions shared by the ALU files.
// ----------------------------------------------------------------------------
`default_nettype none

package z80alu_pkg;

  // Operation codes carried in the mode field.
  localparam logic [4:0] OP_ADD = 5'd0;
  localparam logic [4:0] OP_ADC = 5'd1;
  localparam logic [4:0] OP_SUB = 5'd2;
  localparam logic [4:0] OP_SBC = 5'd3;
  localparam logic [4:0] OP_AND = 5'd4;
  localparam logic [4:0] OP_XOR = 5'd5;
  localparam logic [4:0] OP_OR  = 5'd6;
  localparam logic [4:0] OP_CP  = 5'd7;
  localparam logic [4:0] OP_RLC = 5'd8;
  localparam logic [4:0] OP_RRC = 5'd9;
  localparam logic [4:0] OP_RL  = 5'd10;
  localparam logic [4:0] OP_RR  = 5'd11;
  localparam logic [4:0] OP_SLA = 5'd12;
  localparam logic [4:0] OP_SRA = 5'd13;
  localparam logic [4:0] OP_SLL = 5'd14;
  localparam logic [4:0] OP_SRL = 5'd15;
  localparam logic [4:0] OP_BIT = 5'd16;
  localparam logic [4:0] OP_RES = 5'd17;
  localparam logic [4:0] OP_SET = 5'd18;
  localparam logic [4:0] OP_INC = 5'd19;
  localparam logic [4:0] OP_DEC = 5'd20;
  localparam logic [4:0] OP_NEG = 5'd21;
  localparam logic [4:0] OP_CPL = 5'd22;
  localparam logic [4:0] OP_SCF = 5'd23;
  localparam logic [4:0] OP_CCF = 5'd24;

  // Flag byte bit positions: S Z Y H X P/V N C.
  localparam int unsigned FLAG_S = 7;
  localparam int unsigned FLAG_Z = 6;
  localparam int unsigned FLAG_Y = 5;
  localparam int unsigned FLAG_H = 4;
  localparam int unsigned FLAG_X = 3;
  localparam int unsigned FLAG_P = 2;
  localparam int unsigned FLAG_N = 1;
  localparam int unsigned FLAG_C = 0;

  // Input beat.
  typedef struct packed {
    logic [4:0] mode;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
    logic [7:0] flags_in;
    logic [2:0] bit_index;
  } alu_in_t;

  // Result beat.
  typedef struct packed {
    logic [7:0] result;
    logic [7:0] flags_out;
  } alu_out_t;

endpackage

`default_nettype wire

/* rtl/core/z80_alu_8bit_with_flags_top.sv */
// ----------------------------------------------------------------------------
// Z80 8-bit ALU with flags
// Input register, combinational ALU and result register with valid/ready.
// ----------------------------------------------------------------------------
// The block accepts one operation beat per clock cycle while the result side
// is not stalled and returns one result beat for each, in order. An input beat
// passes through the input register and then the result register, with the
// whole ALU evaluated in the single pass between them.
// The block holds no state between beats; a stall on the result side backs
// up through both registers, so in_ready follows out_ready when both are full.
`default_nettype none

module z80_alu_8bit_with_flags_top (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire z80alu_pkg::alu_in_t in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output z80alu_pkg::alu_out_t     out_data
);
  import z80alu_pkg::*;

  logic     s1_vld_r, s1_vld_nxt;
  alu_in_t  s1_data_r;
  logic     out_vld_r, out_vld_nxt;
  alu_out_t out_data_r;
  alu_out_t alu_res;
  logic     s1_adv;

  // The input register moves on when the result register is free or drains.
  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;

  always_comb begin
    s1_vld_nxt  = (in_valid && in_ready) || (s1_vld_r && !s1_adv);
    out_vld_nxt = s1_adv || (out_vld_r && !out_ready);
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= alu_res;
    end
  end

  z80alu_core u_core (
    .op_i  (s1_data_r),
    .res_o (alu_res)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // Both registers full and the output stalled: no beat may enter.
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && out_vld_r && !out_ready) |-> !in_ready)
    else $error("input accepted while both stages are full and stalled");

  // An accepted input beat occupies the input register next cycle.
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_vld_r)
    else $error("accepted input beat lost");

  // A beat leaving the input register shows as a result next cycle.
  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_vld_r)
    else $error("advancing beat did not reach the result register");

  // The result register holds the ALU output of the beat that moved.
  a_res_match: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_data_r == $past(alu_res)))
    else $error("result register does not match ALU output");

endmodule

`default_nettype wire

/* rtl/core/z80alu_core.sv */
// ----------------------------------------------------------------------------
// Z80 8-bit ALU datapath
// Combinational evaluation of one operation: result byte and new flag byte.
// ----------------------------------------------------------------------------
`default_nettype none

module z80alu_core (
  input  wire z80alu_pkg::alu_in_t op_i,
  output z80alu_pkg::alu_out_t     res_o
);
  import z80alu_pkg::*;

  // Sign, zero and the undocumented Y/X bits taken from a result byte.
  function automatic logic [7:0] sz_yx(input logic [7:0] r);
    logic [7:0] f;
    f         = 8'h00;
    f[FLAG_S] = r[7];
    f[FLAG_Z] = (r == 8'h00);
    f[FLAG_Y] = r[5];
    f[FLAG_X] = r[3];
    return f;
  endfunction

  logic [7:0] a, b, fi;
  logic       cin;

  assign a   = op_i.operand_a;
  assign b   = op_i.operand_b;
  assign fi  = op_i.flags_in;
  assign cin = op_i.flags_in[FLAG_C];

  // Shared adder/subtractor for add, adc, sub, sbc, cp and neg.
  logic       ar_sub;
  logic       ar_cin;
  logic [7:0] ar_x, ar_y, ar_r, ar_f;
  logic [8:0] ar_full;

  always_comb begin
    ar_sub = (op_i.mode == OP_SUB) || (op_i.mode == OP_SBC) ||
             (op_i.mode == OP_CP)  || (op_i.mode == OP_NEG);
    ar_cin = ((op_i.mode == OP_ADC) || (op_i.mode == OP_SBC)) ? cin : 1'b0;
    ar_x   = (op_i.mode == OP_NEG) ? 8'h00 : a;
    ar_y   = (op_i.mode == OP_NEG) ? a : b;
    if (ar_sub) begin
      ar_full = {1'b0, ar_x} - {1'b0, ar_y} - {8'h00, ar_cin};
    end else begin
      ar_full = {1'b0, ar_x} + {1'b0, ar_y} + {8'h00, ar_cin};
    end
    ar_r         = ar_full[7:0];
    ar_f         = sz_yx(ar_r);
    ar_f[FLAG_H] = ar_x[4] ^ ar_y[4] ^ ar_r[4];
    ar_f[FLAG_N] = ar_sub;
    ar_f[FLAG_C] = ar_full[8];
    if (ar_sub) begin
      ar_f[FLAG_P] = (ar_x[7] ^ ar_y[7]) & (ar_x[7] ^ ar_r[7]);
    end else begin
      ar_f[FLAG_P] = ~(ar_x[7] ^ ar_y[7]) & (ar_x[7] ^ ar_r[7]);
    end
  end

  // Operation select.
  logic [7:0] r, f, mask;
  logic       co, tb;

  always_comb begin
    r    = a;
    f    = fi;
    co   = 1'b0;
    mask = 8'h01 << op_i.bit_index;
    tb   = |(a & mask);
    case (op_i.mode)
      OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_NEG: begin
        r = ar_r;
        f = ar_f;
      end
      OP_CP: begin
        f         = ar_f;
        f[FLAG_Y] = b[5];
        f[FLAG_X] = b[3];
      end
      OP_AND: begin
        r         = a & b;
        f         = sz_yx(r);
        f[FLAG_P] = ~^r;
        f[FLAG_H] = 1'b1;
      end
      OP_XOR: begin
        r         = a ^ b;
        f         = sz_yx(r);
        f[FLAG_P] = ~^r;
      end
      OP_OR: begin
        r         = a | b;
        f         = sz_yx(r);
        f[FLAG_P] = ~^r;
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SLL, OP_SRL: begin
        case (op_i.mode)
          OP_RLC: begin co = a[7]; r = {a[6:0], a[7]}; end
          OP_RRC: begin co = a[0]; r = {a[0], a[7:1]}; end
          OP_RL:  begin co = a[7]; r = {a[6:0], cin}; end
          OP_RR:  begin co = a[0]; r = {cin, a[7:1]}; end
          OP_SLA: begin co = a[7]; r = {a[6:0], 1'b0}; end
          OP_SRA: begin co = a[0]; r = {a[7], a[7:1]}; end
          OP_SLL: begin co = a[7]; r = {a[6:0], 1'b1}; end
          default: begin co = a[0]; r = {1'b0, a[7:1]}; end
        endcase
        f         = sz_yx(r);
        f[FLAG_P] = ~^r;
        f[FLAG_C] = co;
      end
      OP_BIT: begin
        f         = 8'h00;
        f[FLAG_S] = tb & (op_i.bit_index == 3'd7);
        f[FLAG_Z] = ~tb;
        f[FLAG_Y] = a[5];
        f[FLAG_H] = 1'b1;
        f[FLAG_X] = a[3];
        f[FLAG_P] = ~tb;
        f[FLAG_C] = cin;
      end
      OP_RES: r = a & ~mask;
      OP_SET: r = a | mask;
      OP_INC: begin
        r         = a + 8'h01;
        f         = sz_yx(r);
        f[FLAG_H] = (a[3:0] == 4'hf);
        f[FLAG_P] = (a == 8'h7f);
        f[FLAG_C] = cin;
      end
      OP_DEC: begin
        r         = a - 8'h01;
        f         = sz_yx(r);
        f[FLAG_H] = (a[3:0] == 4'h0);
        f[FLAG_P] = (a == 8'h80);
        f[FLAG_N] = 1'b1;
        f[FLAG_C] = cin;
      end
      OP_CPL: begin
        r         = ~a;
        f         = fi & 8'hc5;
        f[FLAG_H] = 1'b1;
        f[FLAG_N] = 1'b1;
        f[FLAG_Y] = r[5];
        f[FLAG_X] = r[3];
      end
      OP_SCF: begin
        f         = fi & 8'hc4;
        f[FLAG_C] = 1'b1;
        f[FLAG_Y] = a[5];
        f[FLAG_X] = a[3];
      end
      OP_CCF: begin
        f         = fi & 8'hc4;
        f[FLAG_Y] = a[5];
        f[FLAG_X] = a[3];
        f[FLAG_H] = cin;
        f[FLAG_C] = ~cin;
      end
      default: begin
        // Unassigned codes pass the operand and flags through unchanged.
        r = a;
        f = fi;
      end
    endcase
  end

  assign res_o.result    = r;
  assign res_o.flags_out = f;

endmodule

`default_nettype wire

/* dv/z80_alu_8bit_with_flags_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Z80 8-bit ALU testbench
// Drives operation beats through the valid/ready input channel and checks
// every result beat against a local model of the ALU and its flag logic.
// Covers a directed pass over every operation, random traffic with sender
// bursts and receiver stalls, a long output hold-off and a full drain.
// ----------------------------------------------------------------------------

module z80_alu_8bit_with_flags_top_tb;
  import z80alu_pkg::*;

  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned HOLD_CYCLES  = 80;

  // Flag byte masks built from the package bit positions.
  localparam logic [7:0] F_S = 8'h01 << FLAG_S;
  localparam logic [7:0] F_Z = 8'h01 << FLAG_Z;
  localparam logic [7:0] F_Y = 8'h01 << FLAG_Y;
  localparam logic [7:0] F_H = 8'h01 << FLAG_H;
  localparam logic [7:0] F_X = 8'h01 << FLAG_X;
  localparam logic [7:0] F_P = 8'h01 << FLAG_P;
  localparam logic [7:0] F_N = 8'h01 << FLAG_N;
  localparam logic [7:0] F_C = 8'h01 << FLAG_C;

  // Highest unused operation code.
  localparam logic [4:0] OP_UNUSED_TOP = '1;

  typedef struct {
    alu_in_t  op;
    alu_out_t res;
  } alu_expect_t;

  typedef enum {RX_OPEN, RX_RANDOM, RX_MOSTLY, RX_PERIODIC} rx_style_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  alu_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  alu_out_t out_data;

  alu_expect_t pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 0;
  int unsigned cycle_count;
  bit          gaps_on        = 1'b1;
  bit          hold_req       = 1'b0;

  z80_alu_8bit_with_flags_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // ALU model
  // --------------------------------------------------------------------------

  // Sign, zero and the two undocumented bits, all taken from a result byte.
  function automatic logic [7:0] sign_zero_yx(input logic [7:0] r);
    return (r & (F_S | F_Y | F_X)) | ((r == 8'h00) ? F_Z : 8'h00);
  endfunction

  // P/V as parity: set when the byte has an even number of ones.
  function automatic logic [7:0] parity_bit(input logic [7:0] r);
    return (^r) ? 8'h00 : F_P;
  endfunction

  // Eight-bit add or subtract with carry or borrow in, full flag set.
  function automatic alu_out_t add_sub8(input logic [7:0] a, input logic [7:0] b,
                                        input logic cin, input bit subtract);
    logic [8:0] full;
    alu_out_t   o;
    if (subtract) begin
      full = {1'b0, a} - {1'b0, b} - {8'h00, cin};
    end else begin
      full = {1'b0, a} + {1'b0, b} + {8'h00, cin};
    end
    o.result    = full[7:0];
    o.flags_out = sign_zero_yx(full[7:0]) | ((a ^ b ^ full[7:0]) & F_H);
    if (subtract) begin
      o.flags_out |= F_N;
      if (((a ^ b) & (a ^ full[7:0]) & 8'h80) != 8'h00) o.flags_out |= F_P;
    end else if ((~(a ^ b) & (a ^ full[7:0]) & 8'h80) != 8'h00) begin
      o.flags_out |= F_P;
    end
    // The ninth bit is the carry out, or the borrow for a subtraction.
    if (full[8]) o.flags_out |= F_C;
    return o;
  endfunction

  function automatic alu_out_t alu_predict(input alu_in_t op);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] fi;
    logic [7:0] tested;
    logic       cin;
    logic       co;
    bit         shifter;
    alu_out_t   o;
    a       = op.operand_a;
    b       = op.operand_b;
    fi      = op.flags_in;
    cin     = fi[FLAG_C];
    co      = 1'b0;
    shifter = 1'b0;
    // Unused codes leave both the operand and the flags as they came in.
    o.result    = a;
    o.flags_out = fi;
    case (op.mode)
      OP_ADD: o = add_sub8(a, b, 1'b0, 1'b0);
      OP_ADC: o = add_sub8(a, b, cin, 1'b0);
      OP_SUB: o = add_sub8(a, b, 1'b0, 1'b1);
      OP_SBC: o = add_sub8(a, b, cin, 1'b1);
      OP_AND: begin
        o.result    = a & b;
        o.flags_out = sign_zero_yx(o.result) | parity_bit(o.result) | F_H;
      end
      OP_XOR: begin
        o.result    = a ^ b;
        o.flags_out = sign_zero_yx(o.result) | parity_bit(o.result);
      end
      OP_OR: begin
        o.result    = a | b;
        o.flags_out = sign_zero_yx(o.result) | parity_bit(o.result);
      end
      OP_CP: begin
        // Subtract flags, but Y and X follow the compared operand.
        o = add_sub8(a, b, 1'b0, 1'b1);
        o.flags_out = (o.flags_out & ~(F_Y | F_X)) | (b & (F_Y | F_X));
        o.result    = a;
      end
      OP_RLC: begin co = a[7]; o.result = {a[6:0], a[7]};  shifter = 1'b1; end
      OP_RRC: begin co = a[0]; o.result = {a[0], a[7:1]};  shifter = 1'b1; end
      OP_RL:  begin co = a[7]; o.result = {a[6:0], cin};   shifter = 1'b1; end
      OP_RR:  begin co = a[0]; o.result = {cin, a[7:1]};   shifter = 1'b1; end
      OP_SLA: begin co = a[7]; o.result = {a[6:0], 1'b0};  shifter = 1'b1; end
      OP_SRA: begin co = a[0]; o.result = {a[7], a[7:1]};  shifter = 1'b1; end
      OP_SLL: begin co = a[7]; o.result = {a[6:0], 1'b1};  shifter = 1'b1; end
      OP_SRL: begin co = a[0]; o.result = {1'b0, a[7:1]};  shifter = 1'b1; end
      OP_BIT: begin
        tested      = a & (8'h01 << op.bit_index);
        o.flags_out = F_H | {7'b0, cin} | (a & (F_Y | F_X)) | (tested & F_S);
        if (tested == 8'h00) o.flags_out |= F_Z | F_P;
      end
      OP_RES: o.result = a & ~(8'h01 << op.bit_index);
      OP_SET: o.result = a | (8'h01 << op.bit_index);
      OP_INC: begin
        o.result    = a + 8'h01;
        o.flags_out = sign_zero_yx(o.result) | {7'b0, cin};
        if (a[3:0] == 4'hF) o.flags_out |= F_H;
        if (a == 8'h7F) o.flags_out |= F_P;
      end
      OP_DEC: begin
        o.result    = a - 8'h01;
        o.flags_out = sign_zero_yx(o.result) | {7'b0, cin} | F_N;
        if (a[3:0] == 4'h0) o.flags_out |= F_H;
        if (a == 8'h80) o.flags_out |= F_P;
      end
      OP_NEG: o = add_sub8(8'h00, a, 1'b0, 1'b1);
      OP_CPL: begin
        o.result    = ~a;
        o.flags_out = (fi & (F_S | F_Z | F_P | F_C)) | F_H | F_N | (~a & (F_Y | F_X));
      end
      OP_SCF: o.flags_out = (fi & (F_S | F_Z | F_P)) | F_C | (a & (F_Y | F_X));
      OP_CCF: begin
        o.flags_out = (fi & (F_S | F_Z | F_P)) | (a & (F_Y | F_X)) | (cin ? F_H : F_C);
      end
      default: ;
    endcase
    // Rotates and shifts share one flag rule: result flags plus the bit shifted out.
    if (shifter) o.flags_out = sign_zero_yx(o.result) | parity_bit(o.result) | {7'b0, co};
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic alu_in_t make_op(input logic [4:0] mode, input logic [7:0] a,
                                      input logic [7:0] b, input logic [7:0] fi,
                                      input logic [2:0] bi);
    alu_in_t op;
    op.mode      = mode;
    op.operand_a = a;
    op.operand_b = b;
    op.flags_in  = fi;
    op.bit_index = bi;
    return op;
  endfunction

  // Random byte with a bias towards the values where flags change behaviour.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      4:       return 8'h0F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly real operations, with an occasional unused code.
  function automatic alu_in_t random_op();
    logic [4:0] mode;
    if ($urandom_range(0, 9) == 0) begin
      mode = 5'($urandom_range(OP_CCF + 1, OP_UNUSED_TOP));
    end else begin
      mode = 5'($urandom_range(OP_ADD, OP_CCF));
    end
    return make_op(mode, pick_byte(), pick_byte(), 8'($urandom_range(0, 255)),
                   3'($urandom_range(0, 7)));
  endfunction

  function automatic string describe(input alu_in_t op);
    return $sformatf("mode %0d a %02h b %02h flags %02h bit %0d", op.mode,
                     op.operand_a, op.operand_b, op.flags_in, op.bit_index);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_count++;
  endtask

  // Offers one beat, waits for it to be taken and records its expected result.
  // Between bursts the valid line drops for a random number of cycles.
  task automatic send_op(input alu_in_t op);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_results.push_back('{op: op, res: alu_predict(op)});
    if (!gaps_on || burst_left != 0) begin
      if (burst_left != 0) burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(0, 10);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall pattern and checking
  // --------------------------------------------------------------------------

  int unsigned hold_left  = 0;
  int unsigned rx_stretch = 0;
  int unsigned rx_phase   = 0;
  rx_style_t   rx_style   = RX_OPEN;

  // The receiver switches between stall styles for stretches of random length.
  // A hold-off request keeps it stalled for a long fixed stretch.
  always @(posedge clk) begin
    rx_phase++;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_stretch == 0) begin
        rx_style   = rx_style_t'($urandom_range(0, 3));
        rx_stretch = $urandom_range(20, 150);
      end else begin
        rx_stretch--;
      end
      case (rx_style)
        RX_OPEN:   out_ready <= 1'b1;
        RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
        RX_MOSTLY: out_ready <= ($urandom_range(0, 7) != 0);
        default:   out_ready <= ((rx_phase % 3) != 0);
      endcase
    end
  end

  alu_expect_t head;

  // Each result beat is compared with the oldest expectation, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %02h flags %02h with nothing expected",
                                  out_data.result, out_data.flags_out));
      end else begin
        head = pending_results.pop_front();
        if (out_data.result !== head.res.result) begin
          report_mismatch($sformatf("%s: result %02h, want %02h", describe(head.op),
                                    out_data.result, head.res.result));
        end
        if (out_data.flags_out !== head.res.flags_out) begin
          report_mismatch($sformatf("%s: flags %02h, want %02h", describe(head.op),
                                    out_data.flags_out, head.res.flags_out));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // One pass over every operation at its corner values.
  task automatic test_directed();
    send_op(make_op(OP_ADD, 8'hFF, 8'h01, 8'h00, 3'd0));
    send_op(make_op(OP_ADC, 8'h7F, 8'h00, 8'h01, 3'd0));
    send_op(make_op(OP_SUB, 8'h00, 8'h01, 8'h00, 3'd0));
    send_op(make_op(OP_SBC, 8'h00, 8'hFF, 8'h01, 3'd0));
    send_op(make_op(OP_AND, 8'hFF, 8'hFF, 8'h00, 3'd0));
    send_op(make_op(OP_XOR, 8'hAA, 8'h55, 8'hFF, 3'd0));
    send_op(make_op(OP_OR,  8'h00, 8'h00, 8'hFF, 3'd0));
    // Compare takes Y and X from the second operand, not from the difference.
    send_op(make_op(OP_CP,  8'h28, 8'h28, 8'h00, 3'd0));
    send_op(make_op(OP_CP,  8'h00, 8'hD7, 8'h00, 3'd0));
    send_op(make_op(OP_RLC, 8'h80, 8'h00, 8'h00, 3'd0));
    send_op(make_op(OP_RRC, 8'h01, 8'h00, 8'h00, 3'd0));
    send_op(make_op(OP_RL,  8'h80, 8'h00, 8'h00, 3'd0));
    send_op(make_op(OP_RR,  8'h01, 8'h00, 8'h01, 3'd0));
    send_op(make_op(OP_SLA, 8'hFF, 8'h00, 8'h00, 3'd0));
    send_op(make_op(OP_SRA, 8'h80, 8'h00, 8'h00, 3'd0));
    send_op(make_op(OP_SLL, 8'h00, 8'h00, 8'h00, 3'd0));
    send_op(make_op(OP_SRL, 8'h01, 8'h00, 8'h00, 3'd0));
    // Bit test of bit 7 both set and clear, so sign and zero both show.
    send_op(make_op(OP_BIT, 8'h80, 8'h00, 8'h01, 3'd7));
    send_op(make_op(OP_BIT, 8'h7F, 8'h00, 8'h00, 3'd7));
    send_op(make_op(OP_RES, 8'hFF, 8'h00, 8'hFF, 3'd7));
    send_op(make_op(OP_SET, 8'h00, 8'h00, 8'h00, 3'd0));
    // Increment and decrement keep the incoming carry.
    send_op(make_op(OP_INC, 8'h7F, 8'h00, 8'h01, 3'd0));
    send_op(make_op(OP_DEC, 8'h80, 8'h00, 8'h00, 3'd0));
    send_op(make_op(OP_NEG, 8'h80, 8'h00, 8'h00, 3'd0));
    send_op(make_op(OP_CPL, 8'h00, 8'h00, 8'hD7, 3'd0));
    send_op(make_op(OP_SCF, 8'h28, 8'h00, 8'h00, 3'd0));
    send_op(make_op(OP_CCF, 8'hD7, 8'h00, 8'hFF, 3'd0));
    send_op(make_op(OP_UNUSED_TOP, 8'hAB, 8'hCD, 8'h5A, 3'd5));
  endtask

  task automatic test_random(input int unsigned count);
    repeat (count) send_op(random_op());
  endtask

  // The receiver holds off for a long stretch while beats keep coming,
  // so both registers fill and the input side has to stall.
  task automatic test_backpressure();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_op(random_op());
    gaps_on = 1'b1;
  endtask

  // The sender stops until every outstanding result has come back.
  task automatic test_drain_pause();
    test_random(30);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    test_random(30);
  endtask

  initial begin : main_sequence
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(200);
    test_backpressure();
    test_drain_pause();
    test_random(220);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Ends a run that hangs, for example on a lost result beat.
  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("[%0t] TIMEOUT after %0d cycles, %0d results outstanding", $time,
             cycle_count, pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
